// ===== design/cpq_pkg.sv =====
`timescale 1ns / 1ps
package cpq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int NUM_QUEUES  = 3;
    localparam int DATA_WIDTH  = 32;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QUEUE_W = $clog2(NUM_QUEUES);
    localparam int ADDR_W  = $clog2(NUM_QUEUES * QUEUE_DEPTH);

    // fixed widths of the request and result fields
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ===== design/cpq_ctrl.sv =====
`timescale 1ns / 1ps
module cpq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output cpq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_cmd.load  = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

// ===== design/cpq_datapath.sv =====
`timescale 1ns / 1ps
module cpq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cpq_pkg::t_dp_cmd                    i_cmd,
    input  logic                                i_opcode,
    input  logic signed [cpq_pkg::VALUE_W-1:0]  i_insert_value,
    output logic        [cpq_pkg::STATUS_W-1:0] o_status,
    output logic signed [cpq_pkg::VALUE_W-1:0]  o_popped_value,
    output logic        [cpq_pkg::USED_W-1:0]   o_queue_used
);

    logic                              r_opcode;
    logic [cpq_pkg::DATA_WIDTH-1:0]    r_value;
    logic [cpq_pkg::PTR_W-1:0]         r_rd_ptr [cpq_pkg::NUM_QUEUES];
    logic [cpq_pkg::PTR_W-1:0]         r_wr_ptr [cpq_pkg::NUM_QUEUES];
    logic [cpq_pkg::CNT_W-1:0]         r_count  [cpq_pkg::NUM_QUEUES];
    logic [cpq_pkg::DATA_WIDTH-1:0]    r_mem [cpq_pkg::NUM_QUEUES * cpq_pkg::QUEUE_DEPTH];
    logic [cpq_pkg::DATA_WIDTH-1:0]    r_rd_data;
    logic [cpq_pkg::STATUS_W-1:0]      r_status;
    logic [cpq_pkg::QUEUE_W-1:0]       r_queue;
    logic                              r_pop_ok;

    logic                              ins_found, del_found;
    logic [cpq_pkg::QUEUE_W-1:0]       ins_q, del_q, sel_q;
    logic [cpq_pkg::PTR_W-1:0]         sel_ptr;
    logic [cpq_pkg::ADDR_W-1:0]        addr;
    logic                              do_write, do_read;

    function automatic logic [cpq_pkg::PTR_W-1:0] advance(input logic [cpq_pkg::PTR_W-1:0] p);
        return (p == cpq_pkg::PTR_W'(cpq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // lowest-numbered queue with room / with data
    always_comb begin
        ins_found = 1'b0;
        del_found = 1'b0;
        ins_q     = '0;
        del_q     = '0;
        for (int q = 0; q < cpq_pkg::NUM_QUEUES; q++) begin
            if (!ins_found && (r_count[q] != cpq_pkg::CNT_W'(cpq_pkg::QUEUE_DEPTH))) begin
                ins_found = 1'b1;
                ins_q     = cpq_pkg::QUEUE_W'(q);
            end
            if (!del_found && (r_count[q] != '0)) begin
                del_found = 1'b1;
                del_q     = cpq_pkg::QUEUE_W'(q);
            end
        end
    end

    assign do_write = i_cmd.exec && (r_opcode == cpq_pkg::OP_INSERT) && ins_found;
    assign do_read  = i_cmd.exec && (r_opcode == cpq_pkg::OP_DELETE) && del_found;
    assign sel_q    = (r_opcode == cpq_pkg::OP_INSERT) ? ins_q : del_q;
    assign sel_ptr  = (r_opcode == cpq_pkg::OP_INSERT) ? r_wr_ptr[sel_q] : r_rd_ptr[sel_q];
    assign addr     = cpq_pkg::ADDR_W'(sel_q) * cpq_pkg::ADDR_W'(cpq_pkg::QUEUE_DEPTH)
                    + cpq_pkg::ADDR_W'(sel_ptr);

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[addr] <= r_value;
        end
        if (do_read) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode <= i_opcode;
            r_value  <= cpq_pkg::DATA_WIDTH'(i_insert_value);
        end
        if (i_cmd.exec) begin
            r_pop_ok <= do_read;
            r_queue  <= (do_write || do_read) ? sel_q : '0;
            if (r_opcode == cpq_pkg::OP_INSERT) begin
                r_status <= ins_found ? cpq_pkg::ST_DONE : cpq_pkg::ST_FULL;
            end else begin
                r_status <= del_found ? cpq_pkg::ST_DONE : cpq_pkg::ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < cpq_pkg::NUM_QUEUES; q++) begin
                r_rd_ptr[q] <= '0;
                r_wr_ptr[q] <= '0;
                r_count[q]  <= '0;
            end
        end else if (do_write) begin
            r_wr_ptr[sel_q] <= advance(r_wr_ptr[sel_q]);
            r_count[sel_q]  <= r_count[sel_q] + 1'b1;
        end else if (do_read) begin
            r_rd_ptr[sel_q] <= advance(r_rd_ptr[sel_q]);
            r_count[sel_q]  <= r_count[sel_q] - 1'b1;
        end
    end

    assign o_status       = r_status;
    assign o_popped_value = r_pop_ok ? signed'(cpq_pkg::VALUE_W'(r_rd_data)) : '0;
    assign o_queue_used   = cpq_pkg::USED_W'(r_queue);

endmodule

// ===== design/cascaded_priority_queues.sv =====
`timescale 1ns / 1ps
// flow: a request is accepted in idle, executed in the execute state, then shown in the result state
// only one request is in flight; a new one is accepted only after the result has been taken
// the controller steps idle -> execute -> result for each request
// reset: synchronous active-low; all queues empty, pointers and counts at zero
// entry storage is not cleared; only written entries are ever read
module cascaded_priority_queues (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_opcode,
    input  logic signed [cpq_pkg::VALUE_W-1:0]  i_insert_value,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic        [cpq_pkg::STATUS_W-1:0] o_status,
    output logic signed [cpq_pkg::VALUE_W-1:0]  o_popped_value,
    output logic        [cpq_pkg::USED_W-1:0]   o_queue_used
);

    // command bundle from controller to datapath
    cpq_pkg::t_dp_cmd cmd;

    // controller: accepts a request when idle, runs the execute state,
    // then holds the result until the downstream side takes it
    cpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    // datapath: per-queue pointers and counts, shared entry memory,
    // priority pick of the lowest queue with room or with data
    cpq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_opcode),
        .i_insert_value (i_insert_value),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_queue_used   (o_queue_used)
    );

    // a pending result blocks new requests
    a_result_blocks_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request side open while a result is pending");

    // a result never appears in the cycle right after acceptance
    a_exec_before_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !o_valid)
        else $error("result valid without an execute cycle");

    // failed operations report zero value and queue zero
    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != cpq_pkg::ST_DONE)) |->
            (o_popped_value == '0) && (o_queue_used == '0))
        else $error("failed operation carries nonzero fields");

    // status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == cpq_pkg::ST_DONE) || (o_status == cpq_pkg::ST_FULL)
                    || (o_status == cpq_pkg::ST_EMPTY))
        else $error("undefined status code");

endmodule
